// ===== rtl/core/dpd_pkg.sv =====
// shared constants, mode codes and types of the date period distance block
package dpd_pkg;

  // field widths
  localparam int unsigned ModeW  = 3;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned DistW  = 31;

  // day number and week quotient widths (signed)
  localparam int unsigned JW = 25;
  localparam int unsigned QW = 22;

  // period mode codes
  localparam logic [ModeW-1:0] MODE_MONTHS = 3'd0;
  localparam logic [ModeW-1:0] MODE_WEEKS  = 3'd1;
  localparam logic [ModeW-1:0] MODE_DAYS   = 3'd2;
  localparam logic [ModeW-1:0] MODE_SHIFTS = 3'd3;
  localparam logic [ModeW-1:0] MODE_SLOTS  = 3'd4;

  // day number offsets
  localparam logic signed [JW-1:0] DAY_BASE  = 25'sd1721115;
  localparam logic signed [JW-1:0] WEEK_BASE = 25'sd2440591;

  // reciprocal for floor(x / 100), exact for 0 <= x < 2^14
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int unsigned CENT_SHIFT = 19;

  // reciprocal for floor(x / 7), exact for 0 <= x < 2^23
  localparam logic [23:0] WEEK_RECIP = 24'd9586981;
  localparam int unsigned WEEK_SHIFT = 26;

  // floor((36700 * month - 104595) / 1200) for every 4-bit month code
  localparam logic signed [9:0] MONTH_OFFSET [16] = '{
    -10'sd88, -10'sd57, -10'sd26, 10'sd4,   10'sd35,  10'sd65,  10'sd96,  10'sd126,
    10'sd157, 10'sd188, 10'sd218, 10'sd249, 10'sd279, 10'sd310, 10'sd341, 10'sd371
  };

  // load enables for the two day number stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_ld_t;

endpackage

// ===== rtl/core/date_period_distance.sv =====
// date period distance top level: input register, day number pipeline, result register
//
// Takes a period mode and two dates (year, month, day, hour, minute) and returns the
// signed distance from the first date to the second in months, 7-day weeks, days,
// 8-hour shifts or 10-minute slots; mode codes 5 to 7 give zero. The block is a
// five-register pipeline (input register, two day number stages, week division
// stage, result register) that can take one item every cycle while the output
// is not stalled. Each stage holds its item while the next is full, so a stall
// on the output backs up stage by stage and the input stalls only once all five
// registers are occupied.
module date_period_distance (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dpd_pkg::ModeW-1:0]            period_mode_i,
  input  logic [dpd_pkg::YearW-1:0]            first_year_i,
  input  logic [dpd_pkg::MonthW-1:0]           first_month_i,
  input  logic [dpd_pkg::DayW-1:0]             first_day_i,
  input  logic [dpd_pkg::HourW-1:0]            first_hour_i,
  input  logic [dpd_pkg::MinW-1:0]             first_minute_i,
  input  logic [dpd_pkg::YearW-1:0]            second_year_i,
  input  logic [dpd_pkg::MonthW-1:0]           second_month_i,
  input  logic [dpd_pkg::DayW-1:0]             second_day_i,
  input  logic [dpd_pkg::HourW-1:0]            second_hour_i,
  input  logic [dpd_pkg::MinW-1:0]             second_minute_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dpd_pkg::DistW-1:0]     distance_o
);
  import dpd_pkg::*;

  localparam int unsigned NumStages = 5;

  // pipeline control
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready;
  logic [NumStages-1:0] ld;
  stage_ld_t            day_ld;

  // input register
  logic [ModeW-1:0]  mode0_q;
  logic [YearW-1:0]  y1_q, y2_q;
  logic [MonthW-1:0] m1_q, m2_q;
  logic [DayW-1:0]   d1_q, d2_q;
  logic [HourW-1:0]  h1_q, h2_q;
  logic [MinW-1:0]   n1_q, n2_q;

  // side terms that do not need the day number
  logic signed [14:0] year_diff;
  logic signed [4:0]  month_diff;
  logic signed [5:0]  hour_diff;
  logic [13:0]        n1_prod, n2_prod;
  logic signed [19:0] mdist_d;
  logic signed [2:0]  hq_d;
  logic signed [8:0]  st_d;

  logic [ModeW-1:0]   mode1_q, mode2_q, mode3_q;
  logic signed [19:0] mdist1_q, mdist2_q, mdist3_q;
  logic signed [2:0]  hq1_q, hq2_q, hq3_q;
  logic signed [8:0]  st1_q, st2_q, st3_q;

  // day numbers and week quotients
  logic signed [JW-1:0] j1, j2, w1, w2;
  logic signed [QW-1:0] q1, q2;
  logic signed [JW-1:0] dj3_q;

  // result
  logic signed [31:0]      dj32;
  logic signed [31:0]      dist32;
  logic signed [DistW-1:0] dist_q;

  // ready chain from the output back to the input
  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign ld         = ready & {valid_q[NumStages-2:0], in_valid_i};
  assign in_stall_o = !ready[0];
  assign day_ld     = '{s1: ld[1], s2: ld[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      mode0_q <= period_mode_i;
      y1_q    <= first_year_i;
      m1_q    <= first_month_i;
      d1_q    <= first_day_i;
      h1_q    <= first_hour_i;
      n1_q    <= first_minute_i;
      y2_q    <= second_year_i;
      m2_q    <= second_month_i;
      d2_q    <= second_day_i;
      h2_q    <= second_hour_i;
      n2_q    <= second_minute_i;
    end
  end

  // month, shift and slot terms
  always_comb begin
    year_diff  = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
    month_diff = $signed({1'b0, m2_q}) - $signed({1'b0, m1_q});
    hour_diff  = $signed({1'b0, h2_q}) - $signed({1'b0, h1_q});
    mdist_d    = 20'(year_diff) * 20'sd12 + 20'(month_diff);
    hq_d       = $signed({1'b0, h2_q[4:3]}) - $signed({1'b0, h1_q[4:3]});
    // minute / 10 as a multiply by 205 / 2048
    n1_prod    = 14'(n1_q) * 14'd205;
    n2_prod    = 14'(n2_q) * 14'd205;
    st_d       = 9'(hour_diff) * 9'sd6 + $signed({6'd0, n2_prod[13:11]})
                 - $signed({6'd0, n1_prod[13:11]});
  end

  // side terms travel alongside the day number stages
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      mode1_q  <= mode0_q;
      mdist1_q <= mdist_d;
      hq1_q    <= hq_d;
      st1_q    <= st_d;
    end
    if (ld[2]) begin
      mode2_q  <= mode1_q;
      mdist2_q <= mdist1_q;
      hq2_q    <= hq1_q;
      st2_q    <= st1_q;
    end
    if (ld[3]) begin
      mode3_q  <= mode2_q;
      mdist3_q <= mdist2_q;
      hq3_q    <= hq2_q;
      st3_q    <= st2_q;
      dj3_q    <= j2 - j1;
    end
  end

  dpd_day_number u_day_first (
    .clk_i      (clk_i),
    .ld_i       (day_ld),
    .year_i     (y1_q),
    .month_i    (m1_q),
    .day_i      (d1_q),
    .day_num_o  (j1),
    .week_rel_o (w1)
  );

  dpd_day_number u_day_second (
    .clk_i      (clk_i),
    .ld_i       (day_ld),
    .year_i     (y2_q),
    .month_i    (m2_q),
    .day_i      (d2_q),
    .day_num_o  (j2),
    .week_rel_o (w2)
  );

  dpd_week_quot u_week_first (
    .clk_i  (clk_i),
    .ld_i   (ld[3]),
    .rel_i  (w1),
    .quot_o (q1)
  );

  dpd_week_quot u_week_second (
    .clk_i  (clk_i),
    .ld_i   (ld[3]),
    .rel_i  (w2),
    .quot_o (q2)
  );

  // pick the distance for the mode
  always_comb begin
    dj32 = 32'(dj3_q);
    unique case (mode3_q)
      MODE_MONTHS: dist32 = 32'(mdist3_q);
      MODE_WEEKS:  dist32 = 32'(q2) - 32'(q1);
      MODE_DAYS:   dist32 = dj32;
      MODE_SHIFTS: dist32 = dj32 * 32'sd3 + 32'(hq3_q);
      MODE_SLOTS:  dist32 = dj32 * 32'sd144 + 32'(st3_q);
      default:     dist32 = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      dist_q <= dist32[DistW-1:0];
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign distance_o  = dist_q;

  // input stalls only when every stage holds an item and the output is stalled
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q) && out_stall_i)
    else $error("input stalled with a free pipeline stage");

  // a new result only follows an item in the week stage
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[NumStages-2]))
    else $error("result appeared without a preceding item");

  // unused mode codes give zero
  a_unused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld[4] && !(mode3_q == MODE_MONTHS || mode3_q == MODE_WEEKS || mode3_q == MODE_DAYS ||
               mode3_q == MODE_SHIFTS || mode3_q == MODE_SLOTS)
    |=> distance_o == '0)
    else $error("unused mode code gave a nonzero distance");

endmodule

// ===== rtl/core/dpd_day_number.sv =====
// two-stage day number pipeline for one calendar date
module dpd_day_number (
  input  logic                                clk_i,
  input  dpd_pkg::stage_ld_t                  ld_i,
  input  logic [dpd_pkg::YearW-1:0]           year_i,
  input  logic [dpd_pkg::MonthW-1:0]          month_i,
  input  logic [dpd_pkg::DayW-1:0]            day_i,
  output logic signed [dpd_pkg::JW-1:0]       day_num_o,
  output logic signed [dpd_pkg::JW-1:0]       week_rel_o
);
  import dpd_pkg::*;

  logic signed [14:0]   iy;
  logic [26:0]          cent_prod;
  logic signed [8:0]    cent_d, cent_q;
  logic signed [23:0]   part_a_d, part_a_q;
  logic signed [17:0]   iy3;
  logic signed [16:0]   part_b_d, part_b_q;
  logic signed [10:0]   cent3;
  logic signed [JW-1:0] day_num_d;

  // stage 1: adjusted year, century, year terms
  always_comb begin
    iy        = $signed({1'b0, year_i}) - ((month_i < 4'd3) ? 15'sd1 : 15'sd0);
    cent_prod = 27'(iy[13:0]) * 27'(CENT_RECIP);
    // january or february of year zero gives century minus one
    cent_d    = iy[14] ? -9'sd1 : $signed({1'b0, cent_prod[CENT_SHIFT +: 8]});
    part_a_d  = $signed(24'(year_i) * 24'd367 + 24'(day_i)) + 24'(MONTH_OFFSET[month_i]);
    // ceil(3x/4) = floor((3x+3)/4)
    iy3       = 18'(iy) * 18'sd3 + 18'sd3;
    part_b_d  = 17'(iy) + 17'(iy3 >>> 2);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      cent_q   <= cent_d;
      part_a_q <= part_a_d;
      part_b_q <= part_b_d;
    end
  end

  // stage 2: final day number and its offset from the week origin
  always_comb begin
    cent3     = (11'(cent_q) * 11'sd3 + 11'sd3) >>> 2;
    day_num_d = 25'(part_a_q) - 25'(part_b_q) - 25'(cent3) + DAY_BASE;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      day_num_o  <= day_num_d;
      week_rel_o <= day_num_d - WEEK_BASE;
    end
  end

endmodule

// ===== rtl/core/dpd_week_quot.sv =====
// registered truncating division by seven of a day offset
module dpd_week_quot (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic signed [dpd_pkg::JW-1:0] rel_i,
  output logic signed [dpd_pkg::QW-1:0] quot_o
);
  import dpd_pkg::*;

  logic               neg;
  logic [22:0]        mag;
  logic [46:0]        prod;
  logic [20:0]        quot_mag;
  logic signed [QW-1:0] quot_d;

  // divide the magnitude, then restore the sign (rounds toward zero)
  always_comb begin
    neg      = rel_i[JW-1];
    mag      = neg ? 23'(-rel_i) : 23'(rel_i);
    prod     = 47'(mag) * 47'(WEEK_RECIP);
    quot_mag = prod[WEEK_SHIFT +: 21];
    quot_d   = neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      quot_o <= quot_d;
    end
  end

endmodule
